// ===== rtl/tbrf_pkg.sv =====
// Shared types and constants for the transactional byte ring FIFO.
package tbrf_pkg;

    localparam int unsigned DEPTH_DEF = 256;

    typedef enum logic [2:0] {
        KIND_PUSH    = 3'd0,
        KIND_EXTRACT = 3'd1,
        KIND_PEEK    = 3'd2,
        KIND_COMMIT  = 3'd3,
        KIND_REWIND  = 3'd4
    } kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic start;
        logic load;
    } cmd_t;

endpackage

// ===== rtl/tbrf_if.sv =====
// Request and response channel interfaces of the byte ring FIFO.
interface tbrf_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] push_byte;
    logic [7:0] rewind_marker;

    modport source (output valid, output kind, output push_byte, output rewind_marker,
                    input ready);
    modport sink (input valid, input kind, input push_byte, input rewind_marker,
                  output ready);
endinterface

interface tbrf_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       ok;
    logic [7:0] stored_count;
    logic [7:0] readable_count;
    logic [7:0] free_space;
    logic [7:0] read_offset;

    modport source (output valid, output read_byte, output ok, output stored_count,
                    output readable_count, output free_space, output read_offset,
                    input ready);
    modport sink (input valid, input read_byte, input ok, input stored_count,
                  input readable_count, input free_space, input read_offset,
                  output ready);
endinterface

// ===== rtl/tbrf_ctrl.sv =====
// Controller: sequences one request beat through execute and response load.
module tbrf_ctrl
    import tbrf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    output logic rsp_valid,
    input  logic rsp_ready,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        cmd            = '0;
        req_ready      = 1'b0;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                // take a new beat once the response slot is free or drains now
                req_ready = !rsp_valid_reg || rsp_ready;
                if (req_valid && req_ready)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.load       = 1'b1;
                rsp_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== rtl/tbrf_datapath.sv =====
// Datapath: pointers, byte store and response register of the ring FIFO.
module tbrf_datapath
    import tbrf_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  logic [2:0] kind,
    input  logic [7:0] push_byte,
    input  logic [7:0] rewind_marker,
    output logic [7:0] read_byte,
    output logic       ok,
    output logic [7:0] stored_count,
    output logic [7:0] readable_count,
    output logic [7:0] free_space,
    output logic [7:0] read_offset
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned WW = (AW > 8) ? AW : 8;
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

    logic [7:0] mem [DEPTH];

    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic [AW-1:0] po_reg, po_next;
    logic          ok_reg, ok_next;
    logic          rd_sel_reg, rd_sel_next;
    logic [7:0]    rd_data_reg;
    logic          mem_we;

    logic [AW-1:0] stored;
    logic [AW:0]   sum_rp_po;
    logic [AW-1:0] off_addr;
    logic [AW:0]   wp_plus;
    logic [AW-1:0] wp_inc;
    logic [WW-1:0] marker_w;
    logic [WW-1:0] stored_w;
    logic [WW-1:0] readable_w;
    logic [WW-1:0] free_w;
    logic [WW-1:0] offset_w;

    logic [7:0] read_byte_reg;
    logic       ok_out_reg;
    logic [7:0] stored_count_reg;
    logic [7:0] readable_count_reg;
    logic [7:0] free_space_reg;
    logic [7:0] read_offset_reg;

    // occupancy between committed pointers, modulo depth
    always_comb
    begin
        if (wp_reg >= rp_reg)
        begin
            stored = wp_reg - rp_reg;
        end
        else
        begin
            stored = AW'({1'b0, wp_reg} + DEPTH_W - {1'b0, rp_reg});
        end
    end

    assign sum_rp_po = {1'b0, rp_reg} + {1'b0, po_reg};
    assign off_addr  = (sum_rp_po >= DEPTH_W) ? AW'(sum_rp_po - DEPTH_W)
                                              : sum_rp_po[AW-1:0];
    assign wp_plus   = {1'b0, wp_reg} + (AW + 1)'(1);
    assign wp_inc    = (wp_plus == DEPTH_W) ? '0 : wp_plus[AW-1:0];
    assign marker_w  = WW'(rewind_marker);
    assign stored_w  = WW'(stored);

    always_comb
    begin
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        po_next     = po_reg;
        ok_next     = ok_reg;
        rd_sel_next = rd_sel_reg;
        mem_we      = 1'b0;
        if (cmd.start)
        begin
            ok_next     = 1'b0;
            rd_sel_next = 1'b0;
            case (kind_t'(kind))
                KIND_PUSH:
                begin
                    // drop the byte when full
                    if (stored != LAST)
                    begin
                        mem_we  = 1'b1;
                        wp_next = wp_inc;
                        ok_next = 1'b1;
                    end
                end
                KIND_EXTRACT, KIND_PEEK:
                begin
                    if (po_reg < stored)
                    begin
                        ok_next     = 1'b1;
                        rd_sel_next = 1'b1;
                        if (kind_t'(kind) == KIND_EXTRACT)
                        begin
                            po_next = po_reg + AW'(1);
                        end
                    end
                end
                KIND_COMMIT:
                begin
                    rp_next = off_addr;
                    po_next = '0;
                    ok_next = 1'b1;
                end
                KIND_REWIND:
                begin
                    // clamp a marker past the stored bytes
                    if (marker_w <= stored_w)
                    begin
                        po_next = AW'(marker_w);
                        ok_next = 1'b1;
                    end
                    else
                    begin
                        po_next = stored;
                    end
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            po_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            po_reg <= po_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg     <= ok_next;
        rd_sel_reg <= rd_sel_next;
        if (mem_we)
        begin
            mem[wp_reg] <= push_byte;
        end
        if (cmd.start)
        begin
            rd_data_reg <= mem[off_addr];
        end
    end

    // counts below come from the already updated pointers
    assign readable_w = WW'(stored - po_reg);
    assign free_w     = WW'(LAST - stored);
    assign offset_w   = WW'(po_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            read_byte_reg      <= rd_sel_reg ? rd_data_reg : 8'd0;
            ok_out_reg         <= ok_reg;
            stored_count_reg   <= stored_w[7:0];
            readable_count_reg <= readable_w[7:0];
            free_space_reg     <= free_w[7:0];
            read_offset_reg    <= offset_w[7:0];
        end
    end

    assign read_byte      = read_byte_reg;
    assign ok             = ok_out_reg;
    assign stored_count   = stored_count_reg;
    assign readable_count = readable_count_reg;
    assign free_space     = free_space_reg;
    assign read_offset    = read_offset_reg;

endmodule

// ===== rtl/transactional_byte_ring_fifo.sv =====
// A request beat is accepted in the idle state and executed in the execute state. Its
//   result is then loaded into the response register, from where the result beat is valid.
// The controller takes no new request while in the execute state, so no request is
//   accepted before the previous one has been loaded into the response register.
// A new request is taken while the previous result is being taken.
// Reset clears the pointers, the read offset and all handshake state;
//   the byte store is not cleared and is valid only where pushes wrote it.
module transactional_byte_ring_fifo
    import tbrf_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
)
(
    input logic            clk,
    input logic            rst_n,
    tbrf_req_if.sink       req,
    tbrf_rsp_if.source     rsp
);

    cmd_t cmd;

    tbrf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    tbrf_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .kind           (req.kind),
        .push_byte      (req.push_byte),
        .rewind_marker  (req.rewind_marker),
        .read_byte      (rsp.read_byte),
        .ok             (rsp.ok),
        .stored_count   (rsp.stored_count),
        .readable_count (rsp.readable_count),
        .free_space     (rsp.free_space),
        .read_offset    (rsp.read_offset)
    );

endmodule

// ===== rtl/tbrf_checker.sv =====
// Port-level checks of the byte ring FIFO, bound to the top level.
module tbrf_checker
    import tbrf_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [7:0] read_byte,
    input logic       ok,
    input logic [7:0] stored_count,
    input logic [7:0] readable_count,
    input logic [7:0] free_space,
    input logic [7:0] read_offset
);

    localparam logic [7:0] LAST8 = 8'((DEPTH - 1) % 256);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid
            && $stable({read_byte, ok, stored_count, readable_count, free_space, read_offset}))
        else $error("response beat changed while stalled");

    a_req_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> ##2 rsp_valid)
        else $error("no response two cycles after request beat");

    a_space_sum: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 8'(stored_count + free_space) == LAST8)
        else $error("stored count and free space disagree");

    a_offset_sum: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 8'(read_offset + readable_count) == stored_count)
        else $error("read offset and readable count disagree");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !ok |-> read_byte == 8'd0)
        else $error("failed beat carries a nonzero byte");

endmodule

bind transactional_byte_ring_fifo tbrf_checker #(
    .DEPTH (DEPTH)
) u_tbrf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .read_byte      (rsp.read_byte),
    .ok             (rsp.ok),
    .stored_count   (rsp.stored_count),
    .readable_count (rsp.readable_count),
    .free_space     (rsp.free_space),
    .read_offset    (rsp.read_offset)
);
